>>> rtl/olal_pkg.sv
// Shared types and constants for the ordered array list engine.
`default_nettype none

package olal_pkg;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;

    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_SEARCH = 2'd1;
    localparam t_mode MODE_DELETE = 2'd2;
    localparam t_mode MODE_CLEAR  = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_RANGE     = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned COUNT_W = 7;

    typedef struct packed {
        t_mode                     mode;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] found_index;
        logic [COUNT_W-1:0] element_count;
    } t_res;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_COMPARE,
        CELL_MOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [VALUE_W-1:0] key;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FETCH,
        S_MOVE,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

>>> rtl/olal_cell.sv
// One list slot: holds an entry, shifts from its lower neighbor, compares and reloads.
`default_nettype none

module olal_cell #(
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  wire                              i_clk,
    input  wire olal_pkg::t_cell_ctl         i_ctl,
    input  wire [CW-1:0]                     i_pos,
    input  wire [CW-1:0]                     i_count,
    input  wire [CW-1:0]                     i_sel,
    input  wire [olal_pkg::VALUE_W-1:0]      i_prev,
    output logic [olal_pkg::VALUE_W-1:0]     o_data,
    output logic                             o_match,
    output logic [olal_pkg::VALUE_W-1:0]     o_pick
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [olal_pkg::VALUE_W-1:0] r_data;
    logic [olal_pkg::VALUE_W-1:0] n_data;
    logic                         r_match;
    logic                         n_match;

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        case (i_ctl.op)
            olal_pkg::CELL_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_data = i_ctl.key;
                end else if ((MY_IDX > i_pos) && (MY_IDX <= i_count)) begin
                    n_data = i_prev;
                end
            end
            olal_pkg::CELL_COMPARE: begin
                n_match = (r_data == i_ctl.key) && (MY_IDX < i_count);
            end
            olal_pkg::CELL_MOVE: begin
                if (MY_IDX == i_sel) begin
                    n_data = i_ctl.key;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data  = r_data;
    assign o_match = r_match;
    assign o_pick  = (MY_IDX == i_sel) ? r_data : '0;

endmodule

`default_nettype wire

>>> rtl/ordered_array_list_engine.sv
// Top level: command sequencer and count over a chain of list cells.
// Sequence: insert and clear pass from S_EXEC straight to S_RESP, which strobes o_done;
// search scans one 32-entry group per S_SCAN step; delete adds S_FETCH and S_MOVE.
// Throughput: one transaction at a time; a new one is accepted in the o_done cycle.
// The match scan covers 32 entries per cycle; delete reads the last entry in S_FETCH.
// Synchronous active-low reset empties the list; no receiver stall exists.
`default_nettype none

module ordered_array_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  wire olal_pkg::t_cmd i_cmd,
    output logic            o_done,
    output olal_pkg::t_res  o_result
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int G    = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int NGRP = (CAPACITY + G - 1) / G;
    localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int EW   = $clog2(G);
    localparam int SW   = CW + 1;
    localparam int VW   = olal_pkg::VALUE_W;

    olal_pkg::t_state    r_state;
    olal_pkg::t_state    n_state;
    olal_pkg::t_cmd      r_cmd;
    olal_pkg::t_res      r_res;
    olal_pkg::t_res      n_res;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [GW-1:0]       r_grp;
    logic [GW-1:0]       n_grp;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       n_idx;
    logic [VW-1:0]       r_last;
    logic [VW-1:0]       n_last;

    olal_pkg::t_cell_ctl w_ctl;
    logic [CW-1:0]       w_sel;
    logic [CW-1:0]       w_pos;
    logic [VW-1:0]       w_data [CAPACITY];
    logic [VW-1:0]       w_pick [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic [NGRP*G-1:0]   w_match_pad;
    logic [G-1:0]        w_grp_bits;
    logic                w_hit;
    logic [EW-1:0]       w_enc;
    logic [CW-1:0]       w_found;
    logic [SW-1:0]       w_grp_end;
    logic                w_scan_end;
    logic [VW-1:0]       w_last;
    logic                w_accept;

    assign w_pos    = CW'(r_cmd.position);
    assign busy     = (r_state != olal_pkg::S_IDLE) && (r_state != olal_pkg::S_RESP);
    assign w_accept = start && !busy;
    assign o_done   = (r_state == olal_pkg::S_RESP);
    assign o_result = r_res;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        olal_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_count (r_count),
            .i_sel   (w_sel),
            .i_prev  ((g == 0) ? '0 : w_data[(g == 0) ? 0 : g - 1]),
            .o_data  (w_data[g]),
            .o_match (w_match[g]),
            .o_pick  (w_pick[g])
        );
    end

    always_comb begin
        w_last = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_last = w_last | w_pick[i];
        end
    end

    always_comb begin
        w_match_pad = '0;
        w_match_pad[CAPACITY-1:0] = w_match;
        w_grp_bits = w_match_pad[r_grp*G +: G];
        w_hit = |w_grp_bits;
        w_enc = '0;
        for (int i = G - 1; i >= 0; i--) begin
            if (w_grp_bits[i]) begin
                w_enc = EW'(i);
            end
        end
        w_found    = CW'(r_grp) * CW'(G) + CW'(w_enc);
        w_grp_end  = (SW'(r_grp) + SW'(1)) * SW'(G);
        w_scan_end = (w_grp_end >= SW'(r_count)) || (r_grp == GW'(NGRP - 1));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            olal_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = olal_pkg::S_EXEC;
                end
            end
            olal_pkg::S_EXEC: begin
                unique case (r_cmd.mode) inside
                    olal_pkg::MODE_SEARCH, olal_pkg::MODE_DELETE: n_state = olal_pkg::S_SCAN;
                    default: n_state = olal_pkg::S_RESP;
                endcase
            end
            olal_pkg::S_SCAN: begin
                if (w_hit) begin
                    n_state = (r_cmd.mode == olal_pkg::MODE_DELETE) ? olal_pkg::S_FETCH
                                                                    : olal_pkg::S_RESP;
                end else if (w_scan_end) begin
                    n_state = olal_pkg::S_RESP;
                end
            end
            olal_pkg::S_FETCH: n_state = olal_pkg::S_MOVE;
            olal_pkg::S_MOVE:  n_state = olal_pkg::S_RESP;
            olal_pkg::S_RESP: begin
                n_state = w_accept ? olal_pkg::S_EXEC : olal_pkg::S_IDLE;
            end
            default: n_state = olal_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl.op  = olal_pkg::CELL_HOLD;
        w_ctl.key = r_cmd.value;
        w_sel     = r_count - CW'(1);
        n_count   = r_count;
        n_res     = r_res;
        n_grp     = r_grp;
        n_idx     = r_idx;
        n_last    = r_last;
        unique case (r_state)
            olal_pkg::S_EXEC: begin
                n_grp = '0;
                unique case (r_cmd.mode) inside
                    olal_pkg::MODE_INSERT: begin
                        n_res.found_index = '0;
                        n_res.element_count = olal_pkg::COUNT_W'(r_count);
                        if (12'(r_cmd.position) > 12'(r_count)) begin
                            n_res.status = olal_pkg::ST_RANGE;
                        end else if (r_count >= CW'(CAPACITY)) begin
                            n_res.status = olal_pkg::ST_FULL;
                        end else begin
                            w_ctl.op = olal_pkg::CELL_INSERT;
                            n_count = r_count + CW'(1);
                            n_res.status = olal_pkg::ST_OK;
                            n_res.element_count = olal_pkg::COUNT_W'(r_count + CW'(1));
                        end
                    end
                    olal_pkg::MODE_SEARCH, olal_pkg::MODE_DELETE: begin
                        w_ctl.op = olal_pkg::CELL_COMPARE;
                    end
                    default: begin
                        n_count = '0;
                        n_res.status = olal_pkg::ST_OK;
                        n_res.found_index = '0;
                        n_res.element_count = '0;
                    end
                endcase
            end
            olal_pkg::S_SCAN: begin
                if (w_hit) begin
                    n_idx = w_found;
                    n_res.status = olal_pkg::ST_OK;
                    n_res.found_index = olal_pkg::INDEX_W'(w_found);
                    n_res.element_count = olal_pkg::COUNT_W'(r_count);
                end else if (w_scan_end) begin
                    n_res.status = olal_pkg::ST_NOT_FOUND;
                    n_res.found_index = '0;
                    n_res.element_count = olal_pkg::COUNT_W'(r_count);
                end else begin
                    n_grp = r_grp + GW'(1);
                end
            end
            olal_pkg::S_FETCH: begin
                n_last = w_last;
            end
            olal_pkg::S_MOVE: begin
                w_ctl.op  = olal_pkg::CELL_MOVE;
                w_ctl.key = r_last;
                w_sel     = r_idx;
                n_count   = r_count - CW'(1);
                n_res.status = olal_pkg::ST_OK;
                n_res.found_index = olal_pkg::INDEX_W'(r_idx);
                n_res.element_count = olal_pkg::COUNT_W'(r_count - CW'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olal_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
        r_res  <= n_res;
        r_grp  <= n_grp;
        r_idx  <= n_idx;
        r_last <= n_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == olal_pkg::S_EXEC))
        else $error("accepted transaction not executed");

    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.element_count == olal_pkg::COUNT_W'(r_count)))
        else $error("reported count differs from list count");

    a_found_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_cmd.mode == olal_pkg::MODE_SEARCH)
         && (o_result.status == olal_pkg::ST_OK)) |-> (r_idx < r_count))
        else $error("search hit beyond list end");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == olal_pkg::S_MOVE) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink list");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the ordered array list engine: directed table, then random operations.
`default_nettype none

module tb_top;

    localparam int CAP          = 64;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_OPS   = 700;
    localparam int QUIET_TAIL   = 80;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        olal_pkg::t_cmd cmd;
        bit             known;
        olal_pkg::t_res res;
    } t_row;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    olal_pkg::t_cmd i_cmd   = '0;
    logic           busy;
    logic           o_done;
    olal_pkg::t_res o_result;

    logic signed [olal_pkg::VALUE_W-1:0] shadow_list [0:CAP-1];
    int                                  shadow_len;
    logic signed [olal_pkg::VALUE_W-1:0] value_pool [0:7];
    olal_pkg::t_res                      awaited_results [$];
    int                                  mismatch_cnt = 0;
    int                                  cycle_cnt    = 0;
    int                                  mode_seen [0:3];
    int                                  status_seen [0:3];
    int                                  longest_list = 0;
    bit                                  idle_on = 1'b1;

    ordered_array_list_engine #(.CAPACITY(CAP)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("run stopped after %0d cycles with %0d results outstanding",
                 cycle_cnt, awaited_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic olal_pkg::t_res apply_list_op(input olal_pkg::t_cmd c);
        olal_pkg::t_res r;
        int             hit;
        int             k;
        r        = '0;
        r.status = olal_pkg::ST_OK;
        hit      = -1;
        case (c.mode) inside
            olal_pkg::MODE_INSERT: begin
                if (c.position > shadow_len) begin
                    r.status = olal_pkg::ST_RANGE;
                end else if (shadow_len >= CAP) begin
                    r.status = olal_pkg::ST_FULL;
                end else begin
                    for (k = shadow_len; k > c.position; k--) begin
                        shadow_list[k] = shadow_list[k-1];
                    end
                    shadow_list[c.position] = c.value;
                    shadow_len++;
                end
            end
            olal_pkg::MODE_SEARCH, olal_pkg::MODE_DELETE: begin
                for (k = 0; k < shadow_len; k++) begin
                    if (hit < 0 && shadow_list[k] == c.value) begin
                        hit = k;
                    end
                end
                if (hit < 0) begin
                    r.status = olal_pkg::ST_NOT_FOUND;
                end else begin
                    r.found_index = hit[olal_pkg::INDEX_W-1:0];
                    if (c.mode == olal_pkg::MODE_DELETE) begin
                        shadow_list[hit] = shadow_list[shadow_len-1];
                        shadow_len--;
                    end
                end
            end
            default: begin
                shadow_len = 0;
            end
        endcase
        r.element_count = shadow_len[olal_pkg::COUNT_W-1:0];
        return r;
    endfunction

    function automatic t_row mk_row(input olal_pkg::t_mode m,
                                    input logic signed [olal_pkg::VALUE_W-1:0] v,
                                    input logic [olal_pkg::POS_W-1:0] p, input bit known,
                                    input olal_pkg::t_status s, input int idx, input int cnt);
        t_row row;
        row.cmd.mode              = m;
        row.cmd.value             = v;
        row.cmd.position          = p;
        row.known                 = known;
        row.res.status            = s;
        row.res.found_index       = idx[olal_pkg::INDEX_W-1:0];
        row.res.element_count     = cnt[olal_pkg::COUNT_W-1:0];
        return row;
    endfunction

    function automatic olal_pkg::t_cmd pick_random_op(input int phase);
        olal_pkg::t_cmd c;
        int             r;
        int             grow_pct;
        int             clear_pct;
        grow_pct  = (phase == 0) ? 75 : (phase == 1) ? 45 : 20;
        clear_pct = (phase == 0) ? 0 : (phase == 1) ? 2 : 1;
        r = $urandom_range(99);
        if (r < clear_pct) begin
            c.mode = olal_pkg::MODE_CLEAR;
        end else if (r < clear_pct + grow_pct) begin
            c.mode = olal_pkg::MODE_INSERT;
        end else if ($urandom_range(1) == 0) begin
            c.mode = olal_pkg::MODE_SEARCH;
        end else begin
            c.mode = olal_pkg::MODE_DELETE;
        end
        if (c.mode != olal_pkg::MODE_INSERT && shadow_len > 0 && $urandom_range(99) < 55) begin
            c.value = shadow_list[$urandom_range(shadow_len - 1)];
        end else if ($urandom_range(99) < 60) begin
            c.value = value_pool[$urandom_range(7)];
        end else begin
            c.value = $urandom;
        end
        r = $urandom_range(99);
        if (r < 80) begin
            c.position = olal_pkg::POS_W'($urandom_range(shadow_len));
        end else if (r < 90) begin
            c.position = shadow_len[olal_pkg::POS_W-1:0];
        end else begin
            c.position = olal_pkg::POS_W'($urandom_range(127));
        end
        return c;
    endfunction

    task automatic issue_cmd(input olal_pkg::t_cmd c, input bit known,
                             input olal_pkg::t_res typed);
        olal_pkg::t_res pred;
        i_cmd <= c;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pred = apply_list_op(c);
        awaited_results.push_back(known ? typed : pred);
        mode_seen[c.mode]++;
        status_seen[pred.status]++;
        if (shadow_len > longest_list) begin
            longest_list = shadow_len;
        end
    endtask

    task automatic maybe_idle();
        if (idle_on && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic check_result(input olal_pkg::t_res got);
        olal_pkg::t_res exp;
        if (awaited_results.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
                $display("unexpected transaction: status %0d index %0d count %0d",
                         got.status, got.found_index, got.element_count);
            end
        end else begin
            exp = awaited_results.pop_front();
            if (got.status !== exp.status || got.found_index !== exp.found_index ||
                got.element_count !== exp.element_count) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("mismatch: status %0d/%0d index %0d/%0d count %0d/%0d (exp/got)",
                             exp.status, got.status, exp.found_index, got.found_index,
                             exp.element_count, got.element_count);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            check_result(o_result);
        end
    end

    initial begin
        t_row           stim_table [$];
        t_row           row;
        olal_pkg::t_res none;
        olal_pkg::t_cmd c;
        int             n;
        none       = '0;
        shadow_len = 0;
        for (n = 0; n < 4; n++) begin
            mode_seen[n]   = 0;
            status_seen[n] = 0;
        end
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = 32'sh0;
        value_pool[3] = -32'sd1;
        for (n = 4; n < 8; n++) begin
            value_pool[n] = $urandom;
        end

        stim_table.push_back(mk_row(olal_pkg::MODE_SEARCH, 5, 0, 1, olal_pkg::ST_NOT_FOUND, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_DELETE, 5, 0, 1, olal_pkg::ST_NOT_FOUND, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_INSERT, 7, 1, 1, olal_pkg::ST_RANGE, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_INSERT, 7, 127, 1, olal_pkg::ST_RANGE, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_CLEAR, 0, 0, 1, olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_INSERT, 32'sh8000_0000, 0, 1,
                                    olal_pkg::ST_OK, 0, 1));
        stim_table.push_back(mk_row(olal_pkg::MODE_INSERT, 32'sh7FFF_FFFF, 1, 1,
                                    olal_pkg::ST_OK, 0, 2));
        stim_table.push_back(mk_row(olal_pkg::MODE_INSERT, -1, 0, 1, olal_pkg::ST_OK, 0, 3));
        stim_table.push_back(mk_row(olal_pkg::MODE_INSERT, 0, 1, 1, olal_pkg::ST_OK, 0, 4));
        stim_table.push_back(mk_row(olal_pkg::MODE_SEARCH, 32'sh7FFF_FFFF, 0, 0,
                                    olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_SEARCH, 32'sh8000_0000, 99, 0,
                                    olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_SEARCH, 32'sh7FFF_FFFE, 0, 1,
                                    olal_pkg::ST_NOT_FOUND, 0, 4));
        stim_table.push_back(mk_row(olal_pkg::MODE_INSERT, -1, 4, 0, olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_SEARCH, -1, 0, 0, olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_DELETE, -1, 0, 0, olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_SEARCH, -1, 0, 0, olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_DELETE, 32'sh7FFF_FFFF, 0, 0,
                                    olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_INSERT, 9, 4, 0, olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_INSERT, 9, 3, 0, olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_DELETE, 32'sh1234_5678, 0, 1,
                                    olal_pkg::ST_NOT_FOUND, 0, 4));
        stim_table.push_back(mk_row(olal_pkg::MODE_DELETE, 32'sh8000_0000, 0, 0,
                                    olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_CLEAR, 0, 64, 1, olal_pkg::ST_OK, 0, 0));
        stim_table.push_back(mk_row(olal_pkg::MODE_SEARCH, -1, 0, 1,
                                    olal_pkg::ST_NOT_FOUND, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < stim_table.size(); n++) begin
            issue_cmd(stim_table[n].cmd, stim_table[n].known, stim_table[n].res);
            maybe_idle();
        end

        // fill to capacity, then hit both insert errors on a full list
        while (shadow_len < CAP) begin
            c.mode     = olal_pkg::MODE_INSERT;
            c.value    = $urandom;
            c.position = olal_pkg::POS_W'($urandom_range(shadow_len));
            issue_cmd(c, 0, none);
            maybe_idle();
        end
        row = mk_row(olal_pkg::MODE_INSERT, 3, 64, 1, olal_pkg::ST_FULL, 0, 64);
        issue_cmd(row.cmd, row.known, row.res);
        row = mk_row(olal_pkg::MODE_INSERT, 3, 65, 1, olal_pkg::ST_RANGE, 0, 64);
        issue_cmd(row.cmd, row.known, row.res);
        row = mk_row(olal_pkg::MODE_SEARCH, shadow_list[CAP-1], 0, 0, olal_pkg::ST_OK, 0, 0);
        issue_cmd(row.cmd, row.known, none);
        row = mk_row(olal_pkg::MODE_DELETE, shadow_list[CAP-1], 0, 0, olal_pkg::ST_OK, 0, 0);
        issue_cmd(row.cmd, row.known, none);
        row = mk_row(olal_pkg::MODE_DELETE, shadow_list[10], 0, 0, olal_pkg::ST_OK, 0, 0);
        issue_cmd(row.cmd, row.known, none);
        row = mk_row(olal_pkg::MODE_CLEAR, 0, 0, 1, olal_pkg::ST_OK, 0, 0);
        issue_cmd(row.cmd, row.known, row.res);

        for (n = 0; n < RANDOM_OPS; n++) begin
            idle_on = (n < RANDOM_OPS - QUIET_TAIL) && ((n / 60) % 4 != 3);
            issue_cmd(pick_random_op((n / 120) % 3), 0, none);
            maybe_idle();
        end
        start <= 1'b0;

        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("%0d transactions: %0d insert, %0d search, %0d delete, %0d clear; %s %0d",
                 mode_seen[0] + mode_seen[1] + mode_seen[2] + mode_seen[3],
                 mode_seen[olal_pkg::MODE_INSERT], mode_seen[olal_pkg::MODE_SEARCH],
                 mode_seen[olal_pkg::MODE_DELETE], mode_seen[olal_pkg::MODE_CLEAR],
                 "longest list", longest_list);
        $display("outcomes: %0d ok, %0d not found, %0d out of range, %0d full; %0d mismatches",
                 status_seen[olal_pkg::ST_OK], status_seen[olal_pkg::ST_NOT_FOUND],
                 status_seen[olal_pkg::ST_RANGE], status_seen[olal_pkg::ST_FULL],
                 mismatch_cnt);
        if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/olal_pkg.sv
rtl/olal_cell.sv
rtl/ordered_array_list_engine.sv
test/tb_top.sv
